// File: hdl/assert_macros.svh
// Assertion macros for the checker file of the trace ring buffer.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, switched off while in reset.
`define STRB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen high, switched off while in reset.
`define STRB_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hdl/strb_pkg.sv
// Shared types and constants of the sequenced trace ring buffer.
// No dependencies; used by every module of the block.
package strb_pkg;

   localparam int DEFAULT_DEPTH         = 32;
   localparam int DEFAULT_PAYLOAD_WIDTH = 32;
   localparam int SEQ_W                 = 32;
   localparam int CNT_W                 = 7;
   localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd32;

   localparam logic CMD_APPEND  = 1'b0;
   localparam logic CMD_COLLECT = 1'b1;

   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_NONE   = 2'd2;

   typedef struct packed {
      logic             cmd;
      logic [31:0]      sample_payload;
      logic [31:0]      after_seq;
      logic [CNT_W-1:0] max_out;
   } strb_req_type;

   typedef struct packed {
      logic [1:0]       reply_kind;
      logic [31:0]      seq_number;
      logic [31:0]      payload_out;
      logic             is_last;
      logic [CNT_W-1:0] stored_count;
      logic [31:0]      overwrite_total;
      logic [31:0]      oldest_seq;
      logic [31:0]      newest_seq;
      logic [CNT_W-1:0] copied_so_far;
   } strb_rsp_type;

endpackage

// File: hdl/sequenced_trace_ring_buffer_core.sv
// Top level of the sequenced trace ring buffer.
// Depends on strb_pkg and strb_store.
//
// Requests enter on start/req_data and are taken at an edge where start is
// high and busy is low. Replies leave on rsp_valid/rsp_data, one cycle each;
// the receiver cannot hold them off, so none is ever stalled.
// An append is written to the entry memory in the cycle it is taken and is
// acknowledged in the next cycle; busy stays low, so appends go at one per
// cycle. A collect raises busy and walks the held entries from the oldest,
// one memory read per cycle (the single read port sets that pace). Samples
// pass through the memory read register and are each held back one step so
// that the final one can carry is_last. The last reply shows in the first
// cycle with busy low. The capacity register is written through
// csr_write_en/csr_write_data and clears the ring; reset sets capacity 32
// and clears the ring too. The memory itself is never cleared: only entries
// written since are read.
// Status fields of each reply follow the buffer state after the request.
module sequenced_trace_ring_buffer_core import strb_pkg::*; #(
   parameter int DEPTH         = DEFAULT_DEPTH,
   parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  strb_req_type     req_data,
   output logic             rsp_valid,
   output strb_rsp_type     rsp_data,
   input  logic             csr_write_en,
   input  logic [CNT_W-1:0] csr_write_data
);

   localparam int AW      = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = SEQ_W + PAYLOAD_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [SEQ_W-1:0] ovw_ff, ovw_in;
   logic [SEQ_W-1:0] next_seq_ff, next_seq_in;

   logic [AW-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0] hits_ff, hits_in;
   logic [SEQ_W-1:0] after_ff, after_in;
   logic [CNT_W-1:0] max_ff, max_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [SEQ_W-1:0] pend_seq_ff, pend_seq_in;
   logic [PAYLOAD_WIDTH-1:0] pend_pay_ff, pend_pay_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [31:0]      pay_ff, pay_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] copied_ff, copied_in;

   logic [CNT_W-1:0]   ring;
   logic               ring_full;
   logic               accept;
   logic               do_append;
   logic               issue;
   logic               hit;
   logic [CNT_W-1:0]   wp_inc;
   logic [CNT_W-1:0]   slot_inc;
   logic [ENTRY_W-1:0] rd_data;
   logic [SEQ_W-1:0]   rd_seq;
   logic [PAYLOAD_WIDTH-1:0] rd_pay;

   // Ring size saturates at the memory depth.
   assign ring      = (cap_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_ff;
   assign ring_full = held_ff >= ring;
   assign accept    = start && (state_ff == ST_IDLE);
   assign do_append = accept && (req_data.cmd == CMD_APPEND) && (ring != '0);
   assign wp_inc    = CNT_W'(wp_ff) + CNT_W'(1);
   assign slot_inc  = CNT_W'(slot_ff) + CNT_W'(1);

   assign issue = (state_ff == ST_SCAN) && (scan_cnt_ff < held_ff) && (hits_ff < max_ff);
   assign rd_seq = rd_data[ENTRY_W-1:PAYLOAD_WIDTH];
   assign rd_pay = rd_data[PAYLOAD_WIDTH-1:0];
   assign hit    = rd_pend_ff && (rd_seq > after_ff) && (hits_ff < max_ff);

   strb_store #(
      .DEPTH (DEPTH),
      .WIDTH (ENTRY_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_append),
      .wr_addr (wp_ff),
      .wr_data ({next_seq_ff, req_data.sample_payload[PAYLOAD_WIDTH-1:0]}),
      .rd_en   (issue),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      wp_in         = wp_ff;
      held_in       = held_ff;
      ovw_in        = ovw_ff;
      next_seq_in   = next_seq_ff;
      slot_in       = slot_ff;
      scan_cnt_in   = scan_cnt_ff;
      hits_in       = hits_ff;
      after_in      = after_ff;
      max_in        = max_ff;
      rd_pend_in    = issue;
      pend_valid_in = pend_valid_ff;
      pend_seq_in   = pend_seq_ff;
      pend_pay_in   = pend_pay_ff;
      rsp_valid_in  = 1'b0;
      kind_in       = kind_ff;
      seq_in        = seq_ff;
      pay_in        = pay_ff;
      last_in       = last_ff;
      copied_in     = copied_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.cmd == CMD_APPEND) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_ACK;
                  seq_in       = (ring != '0) ? next_seq_ff : '0;
                  pay_in       = '0;
                  last_in      = 1'b1;
                  copied_in    = '0;
                  if (do_append) begin
                     next_seq_in = next_seq_ff + SEQ_W'(1);
                     wp_in       = (wp_inc == ring) ? '0 : wp_inc[AW-1:0];
                     if (ring_full) begin
                        ovw_in = ovw_ff + SEQ_W'(1);
                     end else begin
                        held_in = held_ff + CNT_W'(1);
                     end
                  end
               end else begin
                  state_in      = ST_SCAN;
                  slot_in       = ring_full ? wp_ff : '0;
                  scan_cnt_in   = '0;
                  hits_in       = '0;
                  after_in      = req_data.after_seq;
                  max_in        = req_data.max_out;
                  pend_valid_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
               slot_in     = (slot_inc == ring) ? '0 : slot_inc[AW-1:0];
            end
            if (hit) begin
               // A new match releases the one held back: it cannot be last.
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_SAMPLE;
                  seq_in       = pend_seq_ff;
                  pay_in       = 32'(pend_pay_ff);
                  last_in      = 1'b0;
                  copied_in    = hits_ff;
               end
               hits_in       = hits_ff + CNT_W'(1);
               pend_valid_in = 1'b1;
               pend_seq_in   = rd_seq;
               pend_pay_in   = rd_pay;
            end
            if (!issue && !rd_pend_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            last_in      = 1'b1;
            if (pend_valid_ff) begin
               kind_in   = KIND_SAMPLE;
               seq_in    = pend_seq_ff;
               pay_in    = 32'(pend_pay_ff);
               copied_in = hits_ff;
            end else begin
               kind_in   = KIND_NONE;
               seq_in    = '0;
               pay_in    = '0;
               copied_in = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Capacity write re-inits ring; write only while idle, unchecked.
      if (csr_write_en) begin
         cap_in      = csr_write_data;
         wp_in       = '0;
         held_in     = '0;
         ovw_in      = '0;
         next_seq_in = SEQ_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= CAPACITY_RESET;
         wp_ff         <= '0;
         held_ff       <= '0;
         ovw_ff        <= '0;
         next_seq_ff   <= SEQ_W'(1);
         rd_pend_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_cnt_ff   <= '0;
         hits_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         wp_ff         <= wp_in;
         held_ff       <= held_in;
         ovw_ff        <= ovw_in;
         next_seq_ff   <= next_seq_in;
         rd_pend_ff    <= rd_pend_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_cnt_ff   <= scan_cnt_in;
         hits_ff       <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      after_ff    <= after_in;
      max_ff      <= max_in;
      pend_seq_ff <= pend_seq_in;
      pend_pay_ff <= pend_pay_in;
      kind_ff     <= kind_in;
      seq_ff      <= seq_in;
      pay_ff      <= pay_in;
      last_ff     <= last_in;
      copied_ff   <= copied_in;
   end

   // Held sequences are consecutive, so oldest and newest follow from the
   // next sequence and the fill level without a memory read.
   always_comb begin
      rsp_data.reply_kind      = kind_ff;
      rsp_data.seq_number      = seq_ff;
      rsp_data.payload_out     = pay_ff;
      rsp_data.is_last         = last_ff;
      rsp_data.stored_count    = held_ff;
      rsp_data.overwrite_total = ovw_ff;
      rsp_data.oldest_seq      = (held_ff != '0) ? next_seq_ff - SEQ_W'(held_ff) : '0;
      rsp_data.newest_seq      = (held_ff != '0) ? next_seq_ff - SEQ_W'(1) : '0;
      rsp_data.copied_so_far   = copied_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign busy      = (state_ff != ST_IDLE);

endmodule

// File: hdl/strb_store.sv
// Entry memory of the trace ring buffer: one write port, one registered read port.
// Depends on strb_pkg for default sizes.
module strb_store import strb_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH,
   parameter int WIDTH = SEQ_W + DEFAULT_PAYLOAD_WIDTH
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/strb_checker.sv
// Port-level checks for the sequenced trace ring buffer, bound to the top level.
// Depends on strb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module strb_checker import strb_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input strb_req_type     req_data,
   input logic             rsp_valid,
   input strb_rsp_type     rsp_data
);

   logic append_taken;
   logic ack_last;
   logic reply_none;
   logic reply_sample;
   logic zero_copied;

   assign append_taken = start && !busy && (req_data.cmd == CMD_APPEND);
   assign ack_last     = rsp_valid && (rsp_data.reply_kind == KIND_ACK) && rsp_data.is_last;
   assign reply_none   = rsp_valid && (rsp_data.reply_kind == KIND_NONE);
   assign reply_sample = rsp_valid && (rsp_data.reply_kind == KIND_SAMPLE);
   assign zero_copied  = (rsp_data.copied_so_far == '0);

   // Every append is acknowledged in the very next cycle.
   `STRB_ASSERT(a_append_ack, clock, reset, append_taken |=> ack_last, "append ack missing")

   // An empty collect reply is final and counts nothing.
   `STRB_ASSERT(a_none_last, clock, reset, reply_none |-> rsp_data.is_last && zero_copied, "bad empty reply")

   // Sample replies number from one.
   `STRB_ASSERT(a_sample_count, clock, reset, reply_sample |-> !zero_copied, "sample count zero")

   // More samples still to come means the collect is still running.
   `STRB_ASSERT(a_more_busy, clock, reset, rsp_valid && !rsp_data.is_last |-> busy, "non-final reply idle")

   // Reply kinds above the three defined never appear.
   `STRB_NEVER(a_kind_range, clock, reset, rsp_valid && rsp_data.reply_kind > KIND_NONE, "undefined reply kind")

endmodule

bind sequenced_trace_ring_buffer_core strb_checker u_strb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
